[src/yolo_box_decode_unit_assert.svh]
// Assertion macros shared by the decode unit RTL.
// Each macro expects clk and rst_n in scope.
`ifndef YOLO_BOX_DECODE_UNIT_ASSERT_SVH
`define YOLO_BOX_DECODE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define YBD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define YBD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define YBD_ASSERT_IMP(label, ante, cons, msg)
`define YBD_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

[src/ybd_pkg.sv]
package ybd_pkg;

    localparam int LOGIT_W   = 16;
    localparam int CH_W      = 8;
    localparam int GRID_W    = 16;
    localparam int ANCHOR_BITS = 16;
    localparam int STRIDE_W  = 7;
    localparam int OUT_W     = 33;
    localparam int SIG_W     = 17;
    localparam int PROD_W    = OUT_W + ANCHOR_BITS;
    localparam int NUM_STAGES = 5;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 7'd8;
    localparam logic [SIG_W-1:0]    SIG_ONE      = 17'd65536;
    // (2s)^2 * anchor >> 20 is s^2 * anchor >> 18 with round half up
    localparam int SIZE_SHIFT = 18;
    localparam logic [PROD_W-1:0]   SIZE_ROUND   = PROD_W'(1) << (SIZE_SHIFT - 1);

    typedef enum logic [1:0] {
        CLS_POS,
        CLS_SIZE,
        CLS_SCORE
    } ybd_cls_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } ybd_ctrl_t;

    function automatic ybd_cls_t classify(input logic [CH_W-1:0] ch);
        ybd_cls_t cls;
        if (ch <= CH_W'(1)) begin
            cls = CLS_POS;
        end
        else if (ch <= CH_W'(3)) begin
            cls = CLS_SIZE;
        end
        else begin
            cls = CLS_SCORE;
        end
        return cls;
    endfunction

    // Piecewise-linear sigmoid, Q8.8 in, unsigned Q1.16 out (0..65536)
    function automatic logic [SIG_W-1:0] sigmoid(input logic signed [LOGIT_W-1:0] x);
        logic [LOGIT_W-1:0] mag;
        logic [SIG_W-1:0]   s;
        mag = x[LOGIT_W-1] ? (~x + LOGIT_W'(1)) : x;
        if (mag >= LOGIT_W'(1280)) begin
            s = SIG_ONE;
        end
        else if (mag >= LOGIT_W'(608)) begin
            s = SIG_W'({mag[10:0], 3'b000}) + SIG_W'(55296);
        end
        else if (mag >= LOGIT_W'(256)) begin
            s = SIG_W'({mag[9:0], 5'b00000}) + SIG_W'(40960);
        end
        else begin
            s = SIG_W'({mag[7:0], 6'b000000}) + SIG_W'(32768);
        end
        if (x[LOGIT_W-1]) begin
            s = SIG_ONE - s;
        end
        return s;
    endfunction

endpackage

[src/ybd_datapath.sv]
module ybd_datapath (
    input  logic                                  clk,
    input  ybd_pkg::ybd_ctrl_t                    ctrl,
    input  logic [ybd_pkg::STRIDE_W-1:0]          stride_cfg,
    input  logic signed [ybd_pkg::LOGIT_W-1:0]    logit,
    input  logic [ybd_pkg::CH_W-1:0]              channel,
    input  logic signed [ybd_pkg::GRID_W-1:0]     grid_offset,
    input  logic [ybd_pkg::ANCHOR_BITS-1:0]       anchor_size,
    output logic signed [ybd_pkg::OUT_W-1:0]      decoded
);

    localparam int POS_W  = ybd_pkg::GRID_W + 10;
    localparam int PPOS_W = POS_W + ybd_pkg::STRIDE_W + 1;
    localparam int SQ_W   = 2 * ybd_pkg::SIG_W;

    // stage 1: captured input
    logic signed [ybd_pkg::LOGIT_W-1:0] s1_logit_reg;
    ybd_pkg::ybd_cls_t                  s1_cls_reg;
    logic signed [ybd_pkg::GRID_W-1:0]  s1_grid_reg;
    logic [ybd_pkg::ANCHOR_BITS-1:0]    s1_anchor_reg;

    // stage 2: sigmoid
    logic [ybd_pkg::SIG_W-1:0]          s2_sig_reg;
    logic [ybd_pkg::SIG_W-1:0]          s2_sig_next;
    ybd_pkg::ybd_cls_t                  s2_cls_reg;
    logic signed [ybd_pkg::GRID_W-1:0]  s2_grid_reg;
    logic [ybd_pkg::ANCHOR_BITS-1:0]    s2_anchor_reg;

    // stage 3: position product, or s squared, or score
    logic [ybd_pkg::OUT_W-1:0]          s3_val_reg;
    logic [ybd_pkg::OUT_W-1:0]          s3_val_next;
    ybd_pkg::ybd_cls_t                  s3_cls_reg;
    logic [ybd_pkg::ANCHOR_BITS-1:0]    s3_anchor_reg;

    // stage 4: size product
    logic [ybd_pkg::OUT_W-1:0]          s4_val_reg;
    logic [ybd_pkg::PROD_W-1:0]         s4_prod_reg;
    logic [ybd_pkg::PROD_W-1:0]         s4_prod_next;
    ybd_pkg::ybd_cls_t                  s4_cls_reg;

    // stage 5: output
    logic [ybd_pkg::OUT_W-1:0]          decoded_reg;
    logic [ybd_pkg::OUT_W-1:0]          decoded_next;

    logic signed [POS_W-1:0]            pos;
    logic signed [PPOS_W-1:0]           pos_prod;
    logic [SQ_W-1:0]                    sq;
    logic [ybd_pkg::PROD_W-1:0]         rounded;

    assign s2_sig_next = ybd_pkg::sigmoid(s1_logit_reg);

    always_comb
    begin
        pos = $signed({{2{s2_grid_reg[ybd_pkg::GRID_W-1]}}, s2_grid_reg, 8'b0})
            + $signed({9'b0, s2_sig_reg});
        // 2s: sig added a second time
        pos = pos + $signed({9'b0, s2_sig_reg});
        pos_prod = pos * $signed({1'b0, stride_cfg});
        sq = s2_sig_reg * s2_sig_reg;
        unique case (s2_cls_reg)
            ybd_pkg::CLS_POS:   s3_val_next = pos_prod[ybd_pkg::OUT_W-1:0];
            ybd_pkg::CLS_SIZE:  s3_val_next = sq[ybd_pkg::OUT_W-1:0];
            ybd_pkg::CLS_SCORE: s3_val_next = ybd_pkg::OUT_W'(s2_sig_reg);
            default:            s3_val_next = '0;
        endcase
    end

    assign s4_prod_next = s3_val_reg * s3_anchor_reg;

    always_comb
    begin
        rounded = s4_prod_reg + ybd_pkg::SIZE_ROUND;
        if (s4_cls_reg == ybd_pkg::CLS_SIZE) begin
            decoded_next = ybd_pkg::OUT_W'(rounded[ybd_pkg::PROD_W-1:ybd_pkg::SIZE_SHIFT]);
        end
        else begin
            decoded_next = s4_val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0]) begin
            s1_logit_reg  <= logit;
            s1_cls_reg    <= ybd_pkg::classify(channel);
            s1_grid_reg   <= grid_offset;
            s1_anchor_reg <= anchor_size;
        end
        if (ctrl.load[1]) begin
            s2_sig_reg    <= s2_sig_next;
            s2_cls_reg    <= s1_cls_reg;
            s2_grid_reg   <= s1_grid_reg;
            s2_anchor_reg <= s1_anchor_reg;
        end
        if (ctrl.load[2]) begin
            s3_val_reg    <= s3_val_next;
            s3_cls_reg    <= s2_cls_reg;
            s3_anchor_reg <= s2_anchor_reg;
        end
        if (ctrl.load[3]) begin
            s4_val_reg    <= s3_val_reg;
            s4_prod_reg   <= s4_prod_next;
            s4_cls_reg    <= s3_cls_reg;
        end
        if (ctrl.load[4]) begin
            decoded_reg   <= decoded_next;
        end
    end

    assign decoded = $signed(decoded_reg);

endmodule

[src/yolo_box_decode_unit.sv]
// From the input transaction to out_valid an item passes through five register stages:
// capture, sigmoid, first multiply, size multiply, round and select.
// Throughput: one transaction per cycle; a stall on the output backs up stage by stage,
// and the input stalls only when every stage holds an item.
// Reset (rst_n low, asynchronous): all stages empty, stride back to 8.
`include "yolo_box_decode_unit_assert.svh"

module yolo_box_decode_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [ybd_pkg::LOGIT_W-1:0]    logit,
    input  logic [ybd_pkg::CH_W-1:0]              channel,
    input  logic signed [ybd_pkg::GRID_W-1:0]     grid_offset,
    input  logic [ybd_pkg::ANCHOR_BITS-1:0]       anchor_size,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [ybd_pkg::OUT_W-1:0]      decoded,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ybd_pkg::STRIDE_W-1:0]          stride
);

    logic [ybd_pkg::NUM_STAGES-1:0] valid_reg;
    logic [ybd_pkg::NUM_STAGES-1:0] valid_next;
    logic [ybd_pkg::STRIDE_W-1:0]   stride_reg;
    logic [ybd_pkg::STRIDE_W-1:0]   stride_next;
    ybd_pkg::ybd_ctrl_t             ctrl;

    // A stage loads when it is empty or its successor loads
    always_comb
    begin
        ctrl.load[ybd_pkg::NUM_STAGES-1] = !valid_reg[ybd_pkg::NUM_STAGES-1] || !out_stall;
        for (int i = ybd_pkg::NUM_STAGES - 2; i >= 0; i--) begin
            ctrl.load[i] = !valid_reg[i] || ctrl.load[i+1];
        end
        valid_next[0] = ctrl.load[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < ybd_pkg::NUM_STAGES; i++) begin
            valid_next[i] = ctrl.load[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    assign stride_next = cfg_valid ? stride : stride_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg  <= '0;
            stride_reg <= ybd_pkg::STRIDE_RESET;
        end
        else begin
            valid_reg  <= valid_next;
            stride_reg <= stride_next;
        end
    end

    assign in_stall  = !ctrl.load[0];
    assign out_valid = valid_reg[ybd_pkg::NUM_STAGES-1];
    assign cfg_ready = 1'b1;

    ybd_datapath u_datapath (
        .clk         (clk),
        .ctrl        (ctrl),
        .stride_cfg  (stride_reg),
        .logit       (logit),
        .channel     (channel),
        .grid_offset (grid_offset),
        .anchor_size (anchor_size),
        .decoded     (decoded)
    );

    `YBD_ASSERT_IMP(a_stall_only_when_full, in_stall, (&valid_reg) && out_stall, "stall with room")
    `YBD_ASSERT_IMP(a_free_output_frees_input, !out_stall, !in_stall, "stall while draining")
    `YBD_ASSERT_NXT(a_accept_fills_stage1, in_valid && !in_stall, valid_reg[0], "transaction lost")

endmodule
